// ===== design/awf8_pkg.sv =====
// Shared types and constants of the 8-bit ALU with flags.
package awf8_pkg;

    localparam int unsigned OP_W      = 5;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITIDX_W  = 3;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 24;

    // Decimal adjust constants
    localparam logic [BYTE_W-1:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [BYTE_W-1:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [3:0]        DAA_LO_LIMIT = 4'h9;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RRC   = 5'd11,
        OP_RL    = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SRL   = 5'd16,
        OP_SWAP  = 5'd17,
        OP_BIT   = 5'd18,
        OP_SET   = 5'd19,
        OP_RES   = 5'd20,
        OP_DAA   = 5'd21,
        OP_ADD16 = 5'd22
    } op_t;

    typedef struct packed {
        logic carry;
        logic half;
        logic sub;
        logic zero;
    } flags_t;

    typedef struct packed {
        flags_t              flags;
        logic [BITIDX_W-1:0] bit_index;
        logic [WORD_W-1:0]   operand_b;
        logic [WORD_W-1:0]   operand_a;
        logic [OP_W-1:0]     req_type;
    } req_t;

    typedef struct packed {
        flags_t            flags;
        logic [WORD_W-1:0] result_value;
    } rsp_t;

endpackage

// ===== design/alu_with_flags_8bit_unit.sv =====
// Top level of the 8-bit ALU with flags: request register, ALU, result register.
//
//  channel | direction | tdata fields (lowest bit first)                      | bits
//  --------+-----------+------------------------------------------------------+-----
//  s_      | in        | req_type, operand_a, operand_b, bit_index, Z, N, H, C | 48
//  m_      | out       | result_value, Z, N, H, C                              | 24
//
//  One request per cycle sustained while m_tready stays high; each request passes
//  the request register, then the result register after the ALU.
//  The ALU is a single combinational pass with no state between requests.
//  aresetn is synchronous and active low; it clears both valid bits only.
//  A stall on m_tready holds the result register; the request register keeps
//  taking a new request whenever the result register can advance.
module alu_with_flags_8bit_unit (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [4:0] req_type, [20:5] operand_a, [36:21] operand_b, [39:37] bit_index,
    // [40] zero_in, [41] sub_in, [42] half_in, [43] carry_in, [47:44] zero fill
    input  logic [awf8_pkg::S_TDATA_W-1:0]   s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] result_value, [16] zero_out, [17] sub_out, [18] half_out,
    // [19] carry_out, [23:20] zero fill
    output logic [awf8_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned REQ_W = $bits(awf8_pkg::req_t);
    localparam int unsigned RSP_W = $bits(awf8_pkg::rsp_t);

    logic           in_valid_reg;
    logic           in_valid_next;
    awf8_pkg::req_t in_req_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    awf8_pkg::rsp_t out_rsp_reg;
    awf8_pkg::rsp_t alu_rsp;
    logic           out_free;
    logic           out_load;
    logic           in_take;

    // Advance the result register when it is empty or being drained
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = in_valid_reg && out_free;
    // Take a request when the request register is empty or moving on
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold unless loaded
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_req_reg <= awf8_pkg::req_t'(s_tdata[REQ_W-1:0]);
        end
        if (out_load) begin
            out_rsp_reg <= alu_rsp;
        end
    end

    awf8_alu u_alu (
        .req_i (in_req_reg),
        .rsp_o (alu_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(awf8_pkg::M_TDATA_W - RSP_W){1'b0}}, out_rsp_reg};

`ifndef SYNTH
    // An empty result register must never block the request side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("s_tready low while result register empty");

    // A held request must reach the result register when it can advance
    a_request_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("request lost between stages");

    // A blocked request must stay in the request register
    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("stalled request dropped or changed");

    // Byte-wide operations leave the upper result byte clear
    a_upper_byte_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (in_req_reg.req_type != awf8_pkg::OP_ADD16))
        |=> (out_rsp_reg.result_value[15:8] == '0))
        else $error("upper result byte set for a byte operation");
`endif

endmodule

// ===== design/awf8_alu.sv =====
// Combinational ALU datapath: one request in, result and new flags out.
module awf8_alu (
    input  awf8_pkg::req_t req_i,
    output awf8_pkg::rsp_t rsp_o
);

    logic [awf8_pkg::BYTE_W-1:0] a;
    logic [awf8_pkg::BYTE_W-1:0] b;
    logic [awf8_pkg::BYTE_W-1:0] r;
    logic [awf8_pkg::BYTE_W-1:0] bit_mask;
    logic [awf8_pkg::BYTE_W-1:0] daa_tmp;
    logic [awf8_pkg::BYTE_W:0]   sum9;
    logic [awf8_pkg::BYTE_W:0]   diff9;
    logic [4:0]                  sum_lo;
    logic [4:0]                  diff_lo;
    logic [awf8_pkg::WORD_W:0]   sum17;
    logic [12:0]                 sum13;
    logic [awf8_pkg::WORD_W-1:0] result;
    logic                        t;
    logic                        setz;
    awf8_pkg::flags_t            f;
    awf8_pkg::op_t               op;

    assign a        = req_i.operand_a[awf8_pkg::BYTE_W-1:0];
    assign b        = req_i.operand_b[awf8_pkg::BYTE_W-1:0];
    assign op       = awf8_pkg::op_t'(req_i.req_type);
    assign bit_mask = 8'(1) << req_i.bit_index;

    // Carry or borrow only for the with-carry forms
    assign t = req_i.flags.carry & ((op == awf8_pkg::OP_ADC) | (op == awf8_pkg::OP_SBC));

    assign sum9    = {1'b0, a} + {1'b0, b} + 9'(t);
    assign sum_lo  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(t);
    assign diff9   = {1'b0, a} - {1'b0, b} - 9'(t);
    assign diff_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(t);
    assign sum17   = {1'b0, req_i.operand_a} + {1'b0, req_i.operand_b};
    assign sum13   = {1'b0, req_i.operand_a[11:0]} + {1'b0, req_i.operand_b[11:0]};

    always_comb begin
        f       = req_i.flags;
        r       = '0;
        result  = '0;
        setz    = 1'b1;
        daa_tmp = a;
        case (op)
            awf8_pkg::OP_ADD, awf8_pkg::OP_ADC: begin
                r       = sum9[awf8_pkg::BYTE_W-1:0];
                f.half  = sum_lo[4];
                f.carry = sum9[awf8_pkg::BYTE_W];
                f.sub   = 1'b0;
            end
            awf8_pkg::OP_SUB, awf8_pkg::OP_SBC: begin
                r       = diff9[awf8_pkg::BYTE_W-1:0];
                f.half  = diff_lo[4];
                f.carry = diff9[awf8_pkg::BYTE_W];
                f.sub   = 1'b1;
            end
            awf8_pkg::OP_CP: begin
                r       = a;
                f.zero  = (diff9[awf8_pkg::BYTE_W-1:0] == '0);
                f.half  = diff_lo[4];
                f.carry = diff9[awf8_pkg::BYTE_W];
                f.sub   = 1'b1;
                setz    = 1'b0;
            end
            awf8_pkg::OP_AND: begin
                r = a & b;
                f.sub = 1'b0; f.half = 1'b1; f.carry = 1'b0;
            end
            awf8_pkg::OP_XOR: begin
                r = a ^ b;
                f.sub = 1'b0; f.half = 1'b0; f.carry = 1'b0;
            end
            awf8_pkg::OP_OR: begin
                r = a | b;
                f.sub = 1'b0; f.half = 1'b0; f.carry = 1'b0;
            end
            awf8_pkg::OP_INC: begin
                r      = a + 8'd1;
                f.half = (a[3:0] == 4'hF);
                f.sub  = 1'b0;
            end
            awf8_pkg::OP_DEC: begin
                r      = a - 8'd1;
                f.half = (a[3:0] == 4'h0);
                f.sub  = 1'b1;
            end
            awf8_pkg::OP_RLC: begin
                r = {a[6:0], a[7]};
                f.carry = a[7]; f.sub = 1'b0; f.half = 1'b0;
            end
            awf8_pkg::OP_RRC: begin
                r = {a[0], a[7:1]};
                f.carry = a[0]; f.sub = 1'b0; f.half = 1'b0;
            end
            awf8_pkg::OP_RL: begin
                r = {a[6:0], req_i.flags.carry};
                f.carry = a[7]; f.sub = 1'b0; f.half = 1'b0;
            end
            awf8_pkg::OP_RR: begin
                r = {req_i.flags.carry, a[7:1]};
                f.carry = a[0]; f.sub = 1'b0; f.half = 1'b0;
            end
            awf8_pkg::OP_SLA: begin
                r = {a[6:0], 1'b0};
                f.carry = a[7]; f.sub = 1'b0; f.half = 1'b0;
            end
            awf8_pkg::OP_SRA: begin
                r = {a[7], a[7:1]};
                f.carry = a[0]; f.sub = 1'b0; f.half = 1'b0;
            end
            awf8_pkg::OP_SRL: begin
                r = {1'b0, a[7:1]};
                f.carry = a[0]; f.sub = 1'b0; f.half = 1'b0;
            end
            awf8_pkg::OP_SWAP: begin
                r = {a[3:0], a[7:4]};
                f.sub = 1'b0; f.half = 1'b0; f.carry = 1'b0;
            end
            awf8_pkg::OP_BIT: begin
                r      = a;
                f.zero = ((a & bit_mask) == '0);
                f.sub  = 1'b0;
                f.half = 1'b1;
                setz   = 1'b0;
            end
            awf8_pkg::OP_SET: begin
                r    = a | bit_mask;
                setz = 1'b0;
            end
            awf8_pkg::OP_RES: begin
                r    = a & ~bit_mask;
                setz = 1'b0;
            end
            awf8_pkg::OP_DAA: begin
                if (!req_i.flags.sub) begin
                    if (req_i.flags.carry || (a > awf8_pkg::DAA_HI_LIMIT)) begin
                        daa_tmp = a + awf8_pkg::DAA_HI_ADJ;
                        f.carry = 1'b1;
                    end
                    // The upper adjust leaves the low nibble alone
                    if (req_i.flags.half || (a[3:0] > awf8_pkg::DAA_LO_LIMIT)) begin
                        r = daa_tmp + awf8_pkg::DAA_LO_ADJ;
                    end else begin
                        r = daa_tmp;
                    end
                end else begin
                    r = a - (req_i.flags.carry ? awf8_pkg::DAA_HI_ADJ : '0)
                          - (req_i.flags.half ? awf8_pkg::DAA_LO_ADJ : '0);
                end
                f.half = 1'b0;
            end
            awf8_pkg::OP_ADD16: begin
                f.half  = sum13[12];
                f.carry = sum17[awf8_pkg::WORD_W];
                f.sub   = 1'b0;
                setz    = 1'b0;
            end
            default: begin
                // Undefined codes: zero result, flags pass through
                r    = '0;
                setz = 1'b0;
            end
        endcase

        if (op == awf8_pkg::OP_ADD16) begin
            result = sum17[awf8_pkg::WORD_W-1:0];
        end else begin
            result = {8'h00, r};
        end

        if (setz) begin
            f.zero = (r == '0);
        end
    end

    assign rsp_o.result_value = result;
    assign rsp_o.flags        = f;

endmodule

// ===== test/alu_flags_checker.sv =====
// Checker for the 8-bit ALU with flags: predicts every accepted request and compares results.
module alu_flags_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [awf8_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [awf8_pkg::M_TDATA_W-1:0] m_tdata,
    output int unsigned                    mismatches,
    output int unsigned                    outstanding,
    output int unsigned                    results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    awf8_pkg::rsp_t expected_results[$];
    awf8_pkg::rsp_t want;
    awf8_pkg::rsp_t got;
    int unsigned    fail_tally;
    int unsigned    result_tally;

    // Work out the result and new flags of one request.
    function automatic awf8_pkg::rsp_t alu_outcome(awf8_pkg::req_t rq);
        logic [7:0]     a;
        logic [7:0]     b;
        logic [7:0]     r8;
        logic [4:0]     nib;
        logic [8:0]     wide8;
        logic [12:0]    low12;
        logic [16:0]    wide16;
        logic           z;
        logic           n;
        logic           h;
        logic           c;
        logic           cin;
        logic           z_from_byte;
        logic           word_result;
        awf8_pkg::rsp_t o;
        a           = rq.operand_a[7:0];
        b           = rq.operand_b[7:0];
        z           = rq.flags.zero;
        n           = rq.flags.sub;
        h           = rq.flags.half;
        c           = rq.flags.carry;
        cin         = (rq.req_type == awf8_pkg::OP_ADC || rq.req_type == awf8_pkg::OP_SBC)
                      ? c : 1'b0;
        r8          = '0;
        wide16      = '0;
        z_from_byte = 1'b1;
        word_result = 1'b0;
        case (rq.req_type)
            awf8_pkg::OP_ADD, awf8_pkg::OP_ADC: begin
                nib   = a[3:0] + b[3:0] + cin;
                wide8 = a + b + cin;
                h     = nib[4];
                c     = wide8[8];
                r8    = wide8[7:0];
                n     = 1'b0;
            end
            awf8_pkg::OP_SUB, awf8_pkg::OP_SBC, awf8_pkg::OP_CP: begin
                nib   = b[3:0] + cin;
                wide8 = b + cin;
                h     = ({1'b0, a[3:0]} < nib);
                c     = ({1'b0, a} < wide8);
                r8    = a - b - cin;
                n     = 1'b1;
                // compare keeps the accumulator, Z still reflects the difference
                if (rq.req_type == awf8_pkg::OP_CP) begin
                    z           = (r8 == 8'h00);
                    r8          = a;
                    z_from_byte = 1'b0;
                end
            end
            awf8_pkg::OP_AND: begin
                r8 = a & b; n = 1'b0; h = 1'b1; c = 1'b0;
            end
            awf8_pkg::OP_XOR: begin
                r8 = a ^ b; n = 1'b0; h = 1'b0; c = 1'b0;
            end
            awf8_pkg::OP_OR: begin
                r8 = a | b; n = 1'b0; h = 1'b0; c = 1'b0;
            end
            awf8_pkg::OP_INC: begin
                h = (a[3:0] == 4'hF); r8 = a + 8'd1; n = 1'b0;
            end
            awf8_pkg::OP_DEC: begin
                h = (a[3:0] == 4'h0); r8 = a - 8'd1; n = 1'b1;
            end
            awf8_pkg::OP_RLC: begin
                r8 = {a[6:0], a[7]}; c = a[7]; n = 1'b0; h = 1'b0;
            end
            awf8_pkg::OP_RRC: begin
                r8 = {a[0], a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0;
            end
            awf8_pkg::OP_RL: begin
                r8 = {a[6:0], c}; c = a[7]; n = 1'b0; h = 1'b0;
            end
            awf8_pkg::OP_RR: begin
                r8 = {c, a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0;
            end
            awf8_pkg::OP_SLA: begin
                r8 = {a[6:0], 1'b0}; c = a[7]; n = 1'b0; h = 1'b0;
            end
            awf8_pkg::OP_SRA: begin
                r8 = {a[7], a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0;
            end
            awf8_pkg::OP_SRL: begin
                r8 = {1'b0, a[7:1]}; c = a[0]; n = 1'b0; h = 1'b0;
            end
            awf8_pkg::OP_SWAP: begin
                r8 = {a[3:0], a[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0;
            end
            awf8_pkg::OP_BIT: begin
                r8          = a;
                z           = ~a[rq.bit_index];
                n           = 1'b0;
                h           = 1'b1;
                z_from_byte = 1'b0;
            end
            awf8_pkg::OP_SET: begin
                r8               = a;
                r8[rq.bit_index] = 1'b1;
                z_from_byte      = 1'b0;
            end
            awf8_pkg::OP_RES: begin
                r8               = a;
                r8[rq.bit_index] = 1'b0;
                z_from_byte      = 1'b0;
            end
            awf8_pkg::OP_DAA: begin
                r8 = a;
                if (!n) begin
                    if (c || r8 > 8'h99) begin
                        r8 = r8 + 8'h60;
                        c  = 1'b1;
                    end
                    if (h || r8[3:0] > 4'h9) begin
                        r8 = r8 + 8'h06;
                    end
                end else begin
                    if (c) begin
                        r8 = r8 - 8'h60;
                    end
                    if (h) begin
                        r8 = r8 - 8'h06;
                    end
                end
                h = 1'b0;
            end
            awf8_pkg::OP_ADD16: begin
                low12       = rq.operand_a[11:0] + rq.operand_b[11:0];
                wide16      = rq.operand_a + rq.operand_b;
                h           = low12[12];
                c           = wide16[16];
                n           = 1'b0;
                z_from_byte = 1'b0;
                word_result = 1'b1;
            end
            default: begin
                // undefined code: zero result, flags untouched
                r8          = '0;
                z_from_byte = 1'b0;
            end
        endcase
        if (z_from_byte) begin
            z = (r8 == 8'h00);
        end
        o.result_value = word_result ? wide16[15:0] : {8'h00, r8};
        o.flags.zero   = z;
        o.flags.sub    = n;
        o.flags.half   = h;
        o.flags.carry  = c;
        return o;
    endfunction

    function automatic int unsigned field_miss(string name, logic [15:0] exp_v,
                                               logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(alu_outcome(
                    awf8_pkg::req_t'(s_tdata[$bits(awf8_pkg::req_t)-1:0])));
            end
            if (m_tvalid && m_tready) begin
                got = awf8_pkg::rsp_t'(m_tdata[$bits(awf8_pkg::rsp_t)-1:0]);
                result_tally++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: expected nothing, got 0x%0h",
                             $time, m_tdata);
                    fail_tally++;
                end else begin
                    want = expected_results.pop_front();
                    fail_tally += field_miss("result_value", want.result_value,
                                             got.result_value);
                    fail_tally += field_miss("zero_out", 16'(want.flags.zero),
                                             16'(got.flags.zero));
                    fail_tally += field_miss("sub_out", 16'(want.flags.sub),
                                             16'(got.flags.sub));
                    fail_tally += field_miss("half_out", 16'(want.flags.half),
                                             16'(got.flags.half));
                    fail_tally += field_miss("carry_out", 16'(want.flags.carry),
                                             16'(got.flags.carry));
                end
            end
        end
        mismatches      <= fail_tally;
        outstanding     <= expected_results.size();
        results_checked <= result_tally;
    end

endmodule

// ===== test/alu_with_flags_8bit_unit_tb.sv =====
// Testbench top for the 8-bit ALU with flags: stimulus, stalls and the verdict.
module alu_with_flags_8bit_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OP_W      = awf8_pkg::OP_W;
    localparam int unsigned WORD_W    = awf8_pkg::WORD_W;
    localparam int unsigned BITIDX_W  = awf8_pkg::BITIDX_W;
    localparam int unsigned S_TDATA_W = awf8_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W = awf8_pkg::M_TDATA_W;

    localparam int unsigned IDLE_PCT     = 29;    // chance in a hundred of an idle cycle
    localparam int unsigned RANDOM_ITEMS = 1100;
    localparam int unsigned STEADY_FIRST = 450;   // window with no idling on either side
    localparam int unsigned STEADY_LAST  = 650;
    localparam int unsigned DRAIN_CYCLES = 6;     // extra wait to watch for unexpected results
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    // Codes past the last defined operation; the block must zero the result
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 5'd23;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 5'd31;

    // Operand corners: zero, all ones, byte edges, nibble edges, decimal limits
    localparam logic [WORD_W-1:0] CORNERS [8] = '{
        16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h000F, 16'h0FFF, 16'h0099, 16'h8000
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic                 steady_flow = 1'b0;
    int unsigned          requests_sent;
    int unsigned          mismatches;
    int unsigned          outstanding;
    int unsigned          results_checked;

    alu_with_flags_8bit_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alu_flags_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // 12 ns period
    always #6 aclk = ~aclk;

    // Stall the result side at random, except in the steady window
    always @(posedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // Build one request; flags come in as {Z, N, H, C}
    function automatic awf8_pkg::req_t make_req(logic [OP_W-1:0] op, logic [WORD_W-1:0] a,
                                                logic [WORD_W-1:0] b,
                                                logic [BITIDX_W-1:0] bi,
                                                logic [3:0] znhc);
        awf8_pkg::req_t rq;
        rq.req_type    = op;
        rq.operand_a   = a;
        rq.operand_b   = b;
        rq.bit_index   = bi;
        rq.flags.zero  = znhc[3];
        rq.flags.sub   = znhc[2];
        rq.flags.half  = znhc[1];
        rq.flags.carry = znhc[0];
        return rq;
    endfunction

    // Favor corners a quarter of the time, otherwise any 16-bit value
    function automatic logic [WORD_W-1:0] pick_operand();
        if ($urandom_range(3) == 0) begin
            return CORNERS[$urandom_range(7)];
        end
        return WORD_W'($urandom);
    endfunction

    // Offer one request: insert random idle cycles first, then hold it until accepted
    task automatic send_request(input awf8_pkg::req_t rq);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - $bits(awf8_pkg::req_t)){1'b0}}, rq};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    initial begin
        logic [OP_W-1:0] op;

        // Hold reset low before the first request
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every operation at a corner (decimal adjust twice), then the undefined codes
        send_request(make_req(awf8_pkg::OP_ADD, 16'hFFFF, 16'h0001, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_ADC, 16'h000F, 16'h0000, 3'd0, 4'b0001));
        send_request(make_req(awf8_pkg::OP_SUB, 16'h0000, 16'h0001, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_SBC, 16'h0010, 16'h000F, 3'd0, 4'b0001));
        send_request(make_req(awf8_pkg::OP_AND, 16'hFF00, 16'h00FF, 3'd0, 4'b0111));
        send_request(make_req(awf8_pkg::OP_XOR, 16'h005A, 16'h005A, 3'd0, 4'b1111));
        send_request(make_req(awf8_pkg::OP_OR, 16'h0000, 16'h0000, 3'd0, 4'b0111));
        send_request(make_req(awf8_pkg::OP_CP, 16'h003C, 16'h003C, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_INC, 16'h00FF, 16'h0000, 3'd0, 4'b0001));
        send_request(make_req(awf8_pkg::OP_DEC, 16'h0010, 16'h0000, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_RLC, 16'h0080, 16'h0000, 3'd0, 4'b0110));
        send_request(make_req(awf8_pkg::OP_RRC, 16'h0001, 16'h0000, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_RL, 16'h0080, 16'h0000, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_RR, 16'h0001, 16'h0000, 3'd0, 4'b0001));
        send_request(make_req(awf8_pkg::OP_SLA, 16'h0080, 16'h0000, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_SRA, 16'h0081, 16'h0000, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_SRL, 16'h0001, 16'h0000, 3'd0, 4'b1110));
        send_request(make_req(awf8_pkg::OP_SWAP, 16'h00F0, 16'h0000, 3'd0, 4'b0111));
        send_request(make_req(awf8_pkg::OP_BIT, 16'h007F, 16'h0000, 3'd7, 4'b0101));
        send_request(make_req(awf8_pkg::OP_SET, 16'h0000, 16'h0000, 3'd7, 4'b1111));
        send_request(make_req(awf8_pkg::OP_RES, 16'hFFFF, 16'h0000, 3'd0, 4'b0000));
        // Both decimal adjusts after an add, then both after a subtract
        send_request(make_req(awf8_pkg::OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'b0000));
        send_request(make_req(awf8_pkg::OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'b0111));
        // Carry out of bits 11 and 15
        send_request(make_req(awf8_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b1000));
        send_request(make_req(OP_UNDEF_LO, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1111));
        send_request(make_req(OP_UNDEF_HI, 16'h1234, 16'h5678, 3'd3, 4'b0000));

        // Random: mostly defined operations, a few undefined codes
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            steady_flow <= (i >= STEADY_FIRST) && (i < STEADY_LAST);
            if ($urandom_range(99) < 4) begin
                op = OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
            end else begin
                op = OP_W'($urandom_range(awf8_pkg::OP_ADD16));
            end
            send_request(make_req(op, pick_operand(), pick_operand(),
                                  BITIDX_W'($urandom_range(7)), 4'($urandom_range(15))));
        end
        s_tvalid <= 1'b0;

        // Drain: wait until every expected result has arrived, then watch for extras
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests over all operations, undefined codes and operand corners;",
                 requests_sent);
        $display("checked %0d results under random idling on both channels.", results_checked);
        if (mismatches == 0) begin
            $display("alu_with_flags_8bit_unit_tb: PASS");
        end else begin
            $display("alu_with_flags_8bit_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still expected", outstanding);
        $display("alu_with_flags_8bit_unit_tb: FAIL");
        $finish;
    end

endmodule
